### hdl/chained_hash_map_u64_key_defines.svh
// assertion macros for the chained hash map
// no dependencies; included by the top level
`ifndef CHAINED_HASH_MAP_U64_KEY_DEFINES_SVH
`define CHAINED_HASH_MAP_U64_KEY_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CHM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define CHM_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### hdl/chm_pkg.sv
// shared types and constants of the chained hash map
// no dependencies
package chm_pkg;

	localparam int CHM_BUCKET_BITS = 10;
	localparam int CHM_NODES       = 1024;
	localparam int CHM_VALUE_WIDTH = 32;

	// request kinds
	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_SET    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// result status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	// register index
	localparam logic REG_BUCKET_BITS = 1'b0;
	localparam logic [3:0] BUCKET_BITS_RESET = 4'd10;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_NODE,
		ST_UNLINK,
		ST_POP,
		ST_EMIT
	} chm_state_t;

endpackage

### hdl/chained_hash_map_u64_key.sv
// chained hash map with 64-bit keys, bucket heads and node pool in block memories
// depends on chm_pkg and chained_hash_map_u64_key_defines.svh
// A request reads the bucket head and then visits the chain nodes one by one; a remove
// hit adds an unlink step and a set that reuses a freed node adds a pop step, and every
// result then passes through the result register. Clear sweeps every entry of the bucket
// head memory, one entry per cycle, and the same sweep runs after reset, during which no
// request is taken (register writes still work).
// The next request is taken while a result waits in the output register.
`include "chained_hash_map_u64_key_defines.svh"

module chained_hash_map_u64_key import chm_pkg::*; #(
	parameter int BUCKET_BITS = CHM_BUCKET_BITS,
	parameter int NODES       = CHM_NODES,
	parameter int VALUE_WIDTH = CHM_VALUE_WIDTH,
	localparam int NW  = $clog2(NODES + 1),
	localparam int OWP = ((2 + 32 + NW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [95:0]    s_tdata,   // key[63:0], value[95:64]
	input  logic [1:0]     s_tuser,   // kind[1:0]
	// result channel
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [OWP-1:0] m_tdata,   // status[1:0], read_value[33:2], entry_count, zero pad
	// register port
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int NB = 1 << BUCKET_BITS;
	localparam int MW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam logic [NW-1:0] NIL = NW'(NODES);

	// one pool node as stored in the node memory
	typedef struct packed {
		logic [63:0]            key;
		logic [VALUE_WIDTH-1:0] val;
		logic [NW-1:0]          nxt;
	} node_t;

	// memories: bucket heads and node pool
	logic [NW-1:0] head_mem [NB];
	node_t         node_mem [NODES];

	logic [NW-1:0]          head_rd_q;
	node_t                  node_rd_q;
	logic                   head_we, node_we;
	logic [BUCKET_BITS-1:0] head_waddr, head_raddr;
	logic [NW-1:0]          head_wdata;
	logic [$clog2(NODES)-1:0] node_waddr_i, node_raddr_i;
	logic [NW-1:0]          node_waddr, node_raddr;
	node_t                  node_wdata;

	// control and bookkeeping
	chm_state_t             state_q, state_d;
	logic [3:0]             bits_q;
	logic [1:0]             kind_q;
	logic [63:0]            key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BUCKET_BITS-1:0] bkt_q, in_bkt, clr_q, clr_d;
	logic                   clrop_q, clrop_d;
	logic [NW-1:0]          cur_q, cur_d, prev_q, prev_d, headv_q, headv_d;
	node_t                  prevw_q, prevw_d, hitw_q, hitw_d;
	logic [NW-1:0]          free_q, free_d, fresh_q, fresh_d, count_q, count_d;
	logic [1:0]             rs_q, rs_d;
	logic [31:0]            rv_q, rv_d;
	logic                   miss, out_load;
	logic                   s_acc;

	// result register
	logic                   out_valid_q;
	logic [1:0]             out_status_q;
	logic [31:0]            out_val_q;
	logic [NW-1:0]          out_count_q;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OWP'({out_count_q, out_val_q, out_status_q});

	// register port: single register, written at any address with paddr[2] clear, read at every address
	assign pready = 1'b1;
	assign prdata = 32'(bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BUCKET_BITS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_BUCKET_BITS) begin
			bits_q <= pwdata[3:0];
		end
	end

	// bucket index: key masked to the bits in use, saturating at BUCKET_BITS
	always_comb begin
		for (int i = 0; i < BUCKET_BITS; i++) begin
			in_bkt[i] = s_tdata[i] & (5'(i) < {1'b0, bits_q});
		end
	end

	assign node_waddr_i = node_waddr[$clog2(NODES)-1:0];
	assign node_raddr_i = node_raddr[$clog2(NODES)-1:0];

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr_i] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr_i];
	end

	// sequencer: clear sweep, or head read, chain walk, the write-back of a set or remove, then the result
	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = NIL;
		head_raddr = in_bkt;
		node_we    = 1'b0;
		node_waddr = cur_q;
		node_wdata = node_rd_q;
		node_raddr = cur_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		prevw_d    = prevw_q;
		hitw_d     = hitw_q;
		headv_d    = headv_q;
		free_d     = free_q;
		fresh_d    = fresh_q;
		count_d    = count_q;
		rs_d       = rs_q;
		rv_d       = rv_q;
		clr_d      = clr_q;
		clrop_d    = clrop_q;
		miss       = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				clr_d      = clr_q + BUCKET_BITS'(1);
				if (clr_q == '1) begin
					if (clrop_q) begin
						rs_d    = STAT_OK;
						rv_d    = '0;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == KIND_CLEAR) begin
						state_d = ST_CLEAR;
						clr_d   = '0;
						clrop_d = 1'b1;
						free_d  = NIL;
						fresh_d = '0;
						count_d = '0;
					end else begin
						state_d = ST_HEAD;
					end
				end
			end
			ST_HEAD: begin
				headv_d = head_rd_q;
				prev_d  = NIL;
				cur_d   = head_rd_q;
				if (head_rd_q == NIL) begin
					miss = 1'b1;
				end else begin
					node_raddr = head_rd_q;
					state_d    = ST_NODE;
				end
			end
			ST_NODE: begin
				if (node_rd_q.key == key_q) begin
					hitw_d = node_rd_q;
					case (kind_q)
						KIND_LOOKUP: begin
							rs_d    = STAT_OK;
							rv_d    = 32'(node_rd_q.val[MW-1:0]);
							state_d = ST_EMIT;
						end
						KIND_SET: begin
							node_we    = 1'b1;
							node_wdata = '{key: key_q, val: val_q, nxt: node_rd_q.nxt};
							rs_d       = STAT_OK;
							rv_d       = '0;
							state_d    = ST_EMIT;
						end
						default: begin
							// unlink: patch the head or the predecessor
							if (prev_q == NIL) begin
								head_we    = 1'b1;
								head_wdata = node_rd_q.nxt;
							end else begin
								node_we    = 1'b1;
								node_waddr = prev_q;
								node_wdata = '{key: prevw_q.key, val: prevw_q.val,
								               nxt: node_rd_q.nxt};
							end
							state_d = ST_UNLINK;
						end
					endcase
				end else if (node_rd_q.nxt == NIL) begin
					miss = 1'b1;
				end else begin
					prev_d     = cur_q;
					prevw_d    = node_rd_q;
					cur_d      = node_rd_q.nxt;
					node_raddr = node_rd_q.nxt;
				end
			end
			ST_UNLINK: begin
				// push the removed node onto the free list
				node_we    = 1'b1;
				node_wdata = '{key: hitw_q.key, val: hitw_q.val, nxt: free_q};
				free_d     = cur_q;
				if (count_q != '0) begin
					count_d = count_q - NW'(1);
				end
				rs_d    = STAT_OK;
				rv_d    = '0;
				state_d = ST_EMIT;
			end
			ST_POP: begin
				// node read from the free list head, link it at the chain head
				node_we    = 1'b1;
				node_waddr = free_q;
				node_wdata = '{key: key_q, val: val_q, nxt: headv_q};
				head_we    = 1'b1;
				head_wdata = free_q;
				free_d     = node_rd_q.nxt;
				count_d    = count_q + NW'(1);
				rs_d       = STAT_OK;
				rv_d       = '0;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// key absent from its chain
		if (miss) begin
			rv_d = '0;
			if (kind_q == KIND_SET) begin
				if (free_q != NIL) begin
					node_raddr = free_q;
					state_d    = ST_POP;
				end else if (fresh_q != NIL) begin
					node_we    = 1'b1;
					node_waddr = fresh_q;
					node_wdata = '{key: key_q, val: val_q, nxt: headv_d};
					head_we    = 1'b1;
					head_wdata = fresh_q;
					fresh_d    = fresh_q + NW'(1);
					count_d    = count_q + NW'(1);
					rs_d       = STAT_OK;
					state_d    = ST_EMIT;
				end else begin
					rs_d    = STAT_FULL;
					state_d = ST_EMIT;
				end
			end else begin
				rs_d    = STAT_NOTFOUND;
				state_d = ST_EMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			clrop_q <= 1'b0;
			free_q  <= NIL;
			fresh_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			clrop_q <= clrop_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			count_q <= count_d;
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata[63:0];
			val_q  <= VALUE_WIDTH'(s_tdata[64 +: MW]);
			bkt_q  <= in_bkt;
		end
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		prevw_q <= prevw_d;
		hitw_q  <= hitw_d;
		headv_q <= headv_d;
		rs_q    <= rs_d;
		rv_q    <= rv_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= rs_q;
			out_val_q    <= rv_q;
			out_count_q  <= count_q;
		end
	end

	`CHM_ASSERT(a_count_le_used, clk, arst_n, count_q <= fresh_q, "more keys than pool nodes used")
	`CHM_ASSERT(a_free_implies_used, clk, arst_n, (free_q == NIL) || (fresh_q != '0), "free list holds a node never used")
	`CHM_ASSERT(a_node_write_in_pool, clk, arst_n, !node_we || (node_waddr != NIL), "node write to the empty mark")
	`CHM_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, out_load, out_valid_q && state_q == ST_IDLE, "result load lost")

endmodule
